// ===== rtl/core/aop_pkg.sv =====
// shared constants and transaction types for the box overlap push-out core
`default_nettype none

package aop_pkg;

	// coordinate and result widths
	localparam int unsigned COORD_BITS = 24;
	localparam int unsigned PUSH_BITS  = 26;
	localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
	localparam int unsigned NUM_CAND   = 8;

	// push scale of 4137/4096, floor rounding
	localparam int unsigned SCALE_BITS  = 14;
	localparam int unsigned SCALE_SHIFT = 12;
	localparam int unsigned PROD_BITS   = DIFF_BITS + SCALE_BITS;
	localparam int unsigned SH_BITS     = PROD_BITS - SCALE_SHIFT;
	localparam logic signed [SCALE_BITS-1:0] SCALE_NUM = SCALE_BITS'(4137);

	// overlap flags and raw candidate depths after the compare stage
	typedef struct packed {
		logic                               hit;
		logic                               neg;
		logic [NUM_CAND-1:0][DIFF_BITS-1:0] cand;
	} det_t;

	// chosen depth after the minimum search
	typedef struct packed {
		logic                        hit;
		logic                        have;
		logic                        is_x;
		logic signed [DIFF_BITS-1:0] depth;
	} sel_t;

endpackage

`default_nettype wire

// ===== rtl/core/aop_detect.sv =====
// compare stage: interval overlap tests and the eight candidate depths
`default_nettype none

module aop_detect
	import aop_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] own_min_x,
	input  wire logic signed [COORD_BITS-1:0] own_min_y,
	input  wire logic signed [COORD_BITS-1:0] own_max_x,
	input  wire logic signed [COORD_BITS-1:0] own_max_y,
	input  wire logic signed [COORD_BITS-1:0] other_min_x,
	input  wire logic signed [COORD_BITS-1:0] other_min_y,
	input  wire logic signed [COORD_BITS-1:0] other_max_x,
	input  wire logic signed [COORD_BITS-1:0] other_max_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output det_t                              out_data
);

	logic v_s1;
	det_t det_s1;
	det_t det_next;
	logic x_prim, y_prim, x_sec, y_sec, prim;

	// own corners inside the other box
	assign x_prim = (own_min_x >= other_min_x && own_min_x <= other_max_x)
		|| (own_max_x >= other_min_x && own_max_x <= other_max_x);
	assign y_prim = (own_min_y >= other_min_y && own_min_y <= other_max_y)
		|| (own_max_y >= other_min_y && own_max_y <= other_max_y);

	// fallback: other corners inside own box
	assign x_sec = x_prim
		|| (other_min_x >= own_min_x && other_min_x <= own_max_x)
		|| (other_max_x >= own_min_x && other_max_x <= own_max_x);
	assign y_sec = y_prim
		|| (other_min_y >= own_min_y && other_min_y <= own_max_y)
		|| (other_max_y >= own_min_y && other_max_y <= own_max_y);

	assign prim = x_prim && y_prim;

	// candidate depths, other corner minus own corner
	always_comb begin
		det_next.hit     = prim || (x_sec && y_sec);
		det_next.neg     = !prim;
		det_next.cand[0] = DIFF_BITS'(other_min_x) - DIFF_BITS'(own_min_x);
		det_next.cand[1] = DIFF_BITS'(other_max_x) - DIFF_BITS'(own_min_x);
		det_next.cand[2] = DIFF_BITS'(other_min_x) - DIFF_BITS'(own_max_x);
		det_next.cand[3] = DIFF_BITS'(other_max_x) - DIFF_BITS'(own_max_x);
		det_next.cand[4] = DIFF_BITS'(other_min_y) - DIFF_BITS'(own_min_y);
		det_next.cand[5] = DIFF_BITS'(other_max_y) - DIFF_BITS'(own_min_y);
		det_next.cand[6] = DIFF_BITS'(other_min_y) - DIFF_BITS'(own_max_y);
		det_next.cand[7] = DIFF_BITS'(other_max_y) - DIFF_BITS'(own_max_y);
	end

	assign in_ready = !v_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			det_s1 <= det_next;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = det_s1;

endmodule

`default_nettype wire

// ===== rtl/core/aop_select.sv =====
// minimum search: magnitudes, then a registered three-level pick tree
`default_nettype none

module aop_select
	import aop_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire det_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output sel_t      out_data
);

	typedef struct packed {
		logic                  nz;
		logic                  is_x;
		logic [COORD_BITS-1:0] mag;
		logic [DIFF_BITS-1:0]  val;
	} cand_t;

	// later entry wins when nonzero and either the earlier one is zero or it is strictly smaller
	function automatic cand_t pick(cand_t a, cand_t b);
		cand_t r;
		if (b.nz && (!a.nz || b.mag < a.mag)) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

	logic v_s2, v_s3, v_s4, v_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic hit_s2, hit_s3, hit_s4;
	logic neg_s2, neg_s3, neg_s4;
	cand_t [NUM_CAND-1:0]   ent_s2;
	cand_t [NUM_CAND/2-1:0] ent_s3;
	cand_t [NUM_CAND/4-1:0] ent_s4;
	sel_t                   sel_s5;

	cand_t [NUM_CAND-1:0] ent_next;
	cand_t                win;
	sel_t                 sel_next;

	// stall chain, a stage moves when empty or when the next one moves
	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	// magnitude and nonzero flag of each candidate
	always_comb begin
		for (int k = 0; k < NUM_CAND; k++) begin
			ent_next[k].val  = in_data.cand[k];
			ent_next[k].nz   = |in_data.cand[k];
			ent_next[k].is_x = (k < NUM_CAND / 2);
			ent_next[k].mag  = in_data.cand[k][DIFF_BITS-1]
				? COORD_BITS'(-in_data.cand[k]) : COORD_BITS'(in_data.cand[k]);
		end
	end

	// last tree level and sign fix for a fallback hit
	always_comb begin
		win            = pick(ent_s4[0], ent_s4[1]);
		sel_next.hit   = hit_s4;
		sel_next.have  = win.nz;
		sel_next.is_x  = win.is_x;
		sel_next.depth = neg_s4 ? -$signed(win.val) : $signed(win.val);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			ent_s2 <= ent_next;
			hit_s2 <= in_data.hit;
			neg_s2 <= in_data.neg;
		end
		if (rdy_s3 && v_s2) begin
			for (int k = 0; k < NUM_CAND / 2; k++) begin
				ent_s3[k] <= pick(ent_s2[2*k], ent_s2[2*k+1]);
			end
			hit_s3 <= hit_s2;
			neg_s3 <= neg_s2;
		end
		if (rdy_s4 && v_s3) begin
			for (int k = 0; k < NUM_CAND / 4; k++) begin
				ent_s4[k] <= pick(ent_s3[2*k], ent_s3[2*k+1]);
			end
			hit_s4 <= hit_s3;
			neg_s4 <= neg_s3;
		end
		if (rdy_s5 && v_s4) begin
			sel_s5 <= sel_next;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = sel_s5;

endmodule

`default_nettype wire

// ===== rtl/core/aop_scale.sv =====
// scale stage: multiply by 4137, floor shift, place on the chosen axis
`default_nettype none

module aop_scale
	import aop_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire sel_t                        in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             hit,
	output logic signed [PUSH_BITS-1:0]      push_x,
	output logic signed [PUSH_BITS-1:0]      push_y
);

	logic v_s6, v_s7;
	logic rdy_s6, rdy_s7;
	logic hit_s6, have_s6, is_x_s6;
	logic signed [PROD_BITS-1:0] prod_s6;
	logic                        hit_s7;
	logic signed [PUSH_BITS-1:0] push_x_s7, push_y_s7;

	logic signed [PROD_BITS-1:0] depth_ext, scale_ext;
	logic signed [SH_BITS-1:0]   shifted;
	logic signed [PUSH_BITS-1:0] push_val;

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign in_ready = rdy_s6;

	assign depth_ext = PROD_BITS'(in_data.depth);
	assign scale_ext = PROD_BITS'(SCALE_NUM);

	// dropping the low bits of a signed product rounds toward minus infinity
	assign shifted  = prod_s6[PROD_BITS-1:SCALE_SHIFT];
	assign push_val = PUSH_BITS'(shifted);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s6) v_s6 <= in_valid;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s6 && in_valid) begin
			prod_s6 <= depth_ext * scale_ext;
			hit_s6  <= in_data.hit;
			have_s6 <= in_data.have;
			is_x_s6 <= in_data.is_x;
		end
		if (rdy_s7 && v_s6) begin
			hit_s7    <= hit_s6;
			push_x_s7 <= (hit_s6 && have_s6 && is_x_s6) ? push_val : '0;
			push_y_s7 <= (hit_s6 && have_s6 && !is_x_s6) ? push_val : '0;
		end
	end

	assign out_valid = v_s7;
	assign hit       = hit_s7;
	assign push_x    = push_x_s7;
	assign push_y    = push_y_s7;

endmodule

`default_nettype wire

// ===== rtl/core/aabb_overlap_push_out_core.sv =====
// Overlap test and push-out proposal for two axis-aligned 2D boxes in Q16.8.
// One box pair is accepted every clock cycle unless the core is stalled, and
// each transaction gives exactly one result after one compare stage, four
// stages of candidate magnitude and minimum search (a three-level pick tree
// over eight depths), one multiply stage and the output register. Every stage
// holds its transaction under backpressure and fills bubbles, so in_ready is
// low only while all seven stages are full and out_ready is low.
`default_nettype none

module aabb_overlap_push_out_core
	import aop_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] own_min_x,
	input  wire logic signed [COORD_BITS-1:0] own_min_y,
	input  wire logic signed [COORD_BITS-1:0] own_max_x,
	input  wire logic signed [COORD_BITS-1:0] own_max_y,
	input  wire logic signed [COORD_BITS-1:0] other_min_x,
	input  wire logic signed [COORD_BITS-1:0] other_min_y,
	input  wire logic signed [COORD_BITS-1:0] other_max_x,
	input  wire logic signed [COORD_BITS-1:0] other_max_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              hit,
	output logic signed [PUSH_BITS-1:0]       push_x,
	output logic signed [PUSH_BITS-1:0]       push_y
);

	logic det_valid, det_ready;
	det_t det_data;
	logic sel_valid, sel_ready;
	sel_t sel_data;

	// overlap tests and candidate depths
	aop_detect u_detect (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.own_min_x   (own_min_x),
		.own_min_y   (own_min_y),
		.own_max_x   (own_max_x),
		.own_max_y   (own_max_y),
		.other_min_x (other_min_x),
		.other_min_y (other_min_y),
		.other_max_x (other_max_x),
		.other_max_y (other_max_y),
		.out_valid   (det_valid),
		.out_ready   (det_ready),
		.out_data    (det_data)
	);

	// smallest nonzero depth
	aop_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (det_valid),
		.in_ready  (det_ready),
		.in_data   (det_data),
		.out_valid (sel_valid),
		.out_ready (sel_ready),
		.out_data  (sel_data)
	);

	// scaling and output register
	aop_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sel_valid),
		.in_ready  (sel_ready),
		.in_data   (sel_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.push_x    (push_x),
		.push_y    (push_y)
	);

endmodule

`default_nettype wire

// ===== rtl/core/aop_checker.sv =====
// port-level checks for the box overlap push-out core, bound to the top level
`default_nettype none

module aop_checker
	import aop_pkg::*;
(
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         hit,
	input wire logic signed [PUSH_BITS-1:0]  push_x,
	input wire logic signed [PUSH_BITS-1:0]  push_y
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(push_x)
			&& $stable(push_y))
		else $error("stalled result changed");

	// no push without a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> push_x == '0 && push_y == '0)
		else $error("push without hit");

	// push lies on one axis only
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> push_x == '0 || push_y == '0)
		else $error("push on both axes");

	// an empty output register means the pipeline can take a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

endmodule

bind aabb_overlap_push_out_core aop_checker u_aop_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.push_x    (push_x),
	.push_y    (push_y)
);

`default_nettype wire
